/* rtl/arm_capture_balance_safety_fsm_macros.svh */
// Assertion macros used by the top-level RTL module.
`ifndef ARM_CAPTURE_BALANCE_SAFETY_FSM_MACROS_SVH
`define ARM_CAPTURE_BALANCE_SAFETY_FSM_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ACB_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ACB_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/acbs_pkg.sv */
`default_nettype none
package acbs_pkg;

    localparam int unsigned MAX_CAPTURE_SAMPLES = 100000;
    localparam int unsigned MAX_TIMEOUT_US      = 10000000;

    localparam int unsigned CNT_W = 17;
    localparam int unsigned AGE_W = 24;

    localparam logic [2:0] MODE_DISABLED = 3'd0;
    localparam logic [2:0] MODE_READY    = 3'd1;
    localparam logic [2:0] MODE_CAPTURE  = 3'd2;
    localparam logic [2:0] MODE_BALANCE  = 3'd3;
    localparam logic [2:0] MODE_FAULT    = 3'd4;

    localparam logic [3:0] FLT_INVALID = 4'b0001;
    localparam logic [3:0] FLT_TIMEOUT = 4'b0010;
    localparam logic [3:0] FLT_CONFIG  = 4'b0100;
    localparam logic [3:0] FLT_ESCAPE  = 4'b1000;

    localparam logic [1:0] REG_CAPTURE_LIMIT = 2'd0;
    localparam logic [1:0] REG_ESCAPE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_SAMPLES       = 2'd2;
    localparam logic [1:0] REG_TIMEOUT       = 2'd3;

    typedef struct packed {
        logic        arm_cmd;
        logic        fault_clr_cmd;
        logic        sample_ok;
        logic [31:0] angle_bits;
        logic [23:0] sample_age;
    } t_in;

    typedef struct packed {
        logic       balance_enable;
        logic [2:0] mode_out;
        logic [3:0] fault_bits;
    } t_out;

    // Configuration as seen by the step logic.
    typedef struct packed {
        logic [30:0] capture_angle_limit;
        logic [30:0] escape_angle_limit;
        logic [16:0] capture_samples_needed;
        logic [23:0] sample_timeout;
    } t_cfg;

endpackage
`default_nettype wire

/* rtl/acbs_cfg_regs.sv */
`default_nettype none
module acbs_cfg_regs
    import acbs_pkg::*;
#(
    parameter int unsigned P_MAX_CAPTURE = MAX_CAPTURE_SAMPLES,
    parameter int unsigned P_MAX_TIMEOUT = MAX_TIMEOUT_US
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_we,
    input  wire logic [1:0]  i_idx,
    input  wire logic [31:0] i_data,
    output t_cfg             o_cfg,
    output logic             o_limits_ok
);
    t_cfg r_cfg;
    logic r_ok;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                REG_CAPTURE_LIMIT: n_cfg.capture_angle_limit = i_data[30:0];
                REG_ESCAPE_LIMIT:  n_cfg.escape_angle_limit = i_data[30:0];
                REG_SAMPLES:       n_cfg.capture_samples_needed = i_data[16:0];
                REG_TIMEOUT:       n_cfg.sample_timeout = i_data[23:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    // Limit check is registered so the step path sees a single flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capture_angle_limit    <= '0;
            r_cfg.escape_angle_limit     <= '0;
            r_cfg.capture_samples_needed <= 17'd1;
            r_cfg.sample_timeout         <= 24'd10000;
            r_ok                         <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
            r_ok  <= (n_cfg.capture_samples_needed != '0)
                  && ({15'd0, n_cfg.capture_samples_needed} <= P_MAX_CAPTURE[31:0])
                  && (n_cfg.sample_timeout != '0)
                  && ({8'd0, n_cfg.sample_timeout} <= P_MAX_TIMEOUT[31:0]);
        end
    end

    assign o_cfg       = r_cfg;
    assign o_limits_ok = r_ok;
endmodule
`default_nettype wire

/* rtl/acbs_step.sv */
`default_nettype none
module acbs_step
    import acbs_pkg::*;
(
    input  wire logic        i_ok_cfg,
    input  wire t_cfg        i_cfg,
    input  wire t_in         i_item,
    input  wire logic [2:0]  i_mode,
    input  wire logic [3:0]  i_faults,
    input  wire logic [16:0] i_count,
    output logic [2:0]       o_mode,
    output logic [3:0]       o_faults,
    output logic [16:0]      o_count
);
    logic [30:0] mag;
    logic        in_cap;
    logic [16:0] inc;

    assign mag    = i_item.angle_bits[30:0];
    assign in_cap = mag <= i_cfg.capture_angle_limit;
    assign inc    = (i_count < i_cfg.capture_samples_needed) ? i_count + 17'd1 : i_count;

    always_comb begin
        o_mode   = i_mode;
        o_faults = i_faults;
        o_count  = i_count;
        priority if (!i_ok_cfg) begin
            o_faults = i_faults | FLT_CONFIG;
            o_count  = '0;
            o_mode   = MODE_FAULT;
        end else if (i_mode >= MODE_FAULT) begin
            if (!i_item.arm_cmd && i_item.fault_clr_cmd) begin
                o_mode = MODE_DISABLED; o_faults = '0; o_count = '0;
            end
        end else if (!i_item.arm_cmd) begin
            o_mode = MODE_DISABLED; o_faults = '0; o_count = '0;
        end else if (!i_item.sample_ok || (i_item.angle_bits[30:23] == 8'hFF)) begin
            o_faults = i_faults | FLT_INVALID; o_count = '0; o_mode = MODE_FAULT;
        end else if (i_item.sample_age > i_cfg.sample_timeout) begin
            o_faults = i_faults | FLT_TIMEOUT; o_count = '0; o_mode = MODE_FAULT;
        end else if (i_mode == MODE_DISABLED || i_mode == MODE_READY) begin
            if (in_cap) begin
                o_count = 17'd1;
                o_mode  = (17'd1 >= i_cfg.capture_samples_needed) ? MODE_BALANCE
                                                                  : MODE_CAPTURE;
            end else begin
                o_mode = MODE_READY; o_count = '0;
            end
        end else if (i_mode == MODE_CAPTURE) begin
            if (!in_cap) begin
                o_mode = MODE_READY; o_count = '0;
            end else begin
                o_count = inc;
                if (inc >= i_cfg.capture_samples_needed) o_mode = MODE_BALANCE;
            end
        end else begin
            if (mag > i_cfg.escape_angle_limit) begin
                o_faults = i_faults | FLT_ESCAPE; o_count = '0; o_mode = MODE_FAULT;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/arm_capture_balance_safety_fsm.sv */
// Arm, capture and balance safety machine. Each accepted request is one
// control sample; the block answers with exactly one result per request,
// carrying the new mode, a balance enable and the sticky fault flags. The
// step is one level of compares and a counter update between the input
// port and the result register, so a request can be taken every cycle
// while no finished result is held by a downstream stall; its result is
// registered and shown in the cycle after acceptance. Configuration
// registers (0 capture limit, 1 escape limit, 2 samples needed, 3 sample
// timeout) are written through their own valid/ready port, which is always
// ready; they should only be changed while no request is in flight.
`default_nettype none
`include "arm_capture_balance_safety_fsm_macros.svh"
module arm_capture_balance_safety_fsm
    import acbs_pkg::*;
#(
    parameter int unsigned P_MAX_CAPTURE = MAX_CAPTURE_SAMPLES,
    parameter int unsigned P_MAX_TIMEOUT = MAX_TIMEOUT_US
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out             o_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    t_cfg        cfg;
    logic        limits_ok;
    logic [2:0]  r_mode, n_mode;
    logic [3:0]  r_faults, n_faults;
    logic [16:0] r_count, n_count;
    logic        r_out_valid;
    t_out        r_out;
    logic        take;

    assign o_cfg_ready = 1'b1;

    acbs_cfg_regs #(
        .P_MAX_CAPTURE(P_MAX_CAPTURE),
        .P_MAX_TIMEOUT(P_MAX_TIMEOUT)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_valid),
        .i_idx      (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_cfg      (cfg),
        .o_limits_ok(limits_ok)
    );

    acbs_step u_step (
        .i_ok_cfg(limits_ok),
        .i_cfg   (cfg),
        .i_item  (i_data),
        .i_mode  (r_mode),
        .i_faults(r_faults),
        .i_count (r_count),
        .o_mode  (n_mode),
        .o_faults(n_faults),
        .o_count (n_count)
    );

    // The input is held off only while a finished result waits downstream.
    assign o_stall = r_out_valid && i_stall;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DISABLED;
            r_faults    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_mode   <= n_mode;
                r_faults <= n_faults;
                r_count  <= n_count;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.balance_enable <= (n_mode == MODE_BALANCE);
            r_out.mode_out       <= n_mode;
            r_out.fault_bits     <= n_faults;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Balance is only shown together with its mode code.
    `ACB_ASSERT_IMPL(a_bal_mode, i_clk, i_rst_n, o_valid,
        o_data.balance_enable == (o_data.mode_out == MODE_BALANCE), "balance flag mismatch")
    // Any latched fault means fault mode.
    `ACB_ASSERT_IMPL(a_fault_mode, i_clk, i_rst_n, r_faults != 4'd0,
        r_mode == MODE_FAULT, "fault bits outside fault mode")
    // A taken request shows its result, with the new mode, on the next cycle.
    `ACB_ASSERT_NEXT(a_result, i_clk, i_rst_n, take, o_valid && o_data.mode_out == r_mode,
        "result does not follow state")
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none

// Testbench for the arm/capture/balance safety machine. A predictor tracks
// mode, sticky faults and the capture counter. Every accepted request pushes
// the result it should produce. A monitor compares each accepted result with
// the oldest prediction, field by field.
module tb_top;
    import acbs_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    t_out        o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    arm_capture_balance_safety_fsm DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor's copy of the configuration and state.
    logic [30:0] cap_lim = '0;
    logic [30:0] esc_lim = '0;
    logic [16:0] need = 17'd1;
    logic [23:0] tmo = 24'd10000;
    logic [2:0]  md = MODE_DISABLED;
    logic [3:0]  flt = '0;
    logic [16:0] cnt = '0;

    t_out expected_results[$];
    int   errors = 0;
    int   requests_sent = 0;
    int   results_seen = 0;
    int   cycles = 0;
    bit   hold_off = 1'b0;
    bit   stall_free = 1'b0;

    localparam int CYCLE_LIMIT = 400000;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] exp);
        $display("mismatch on %s: got %0h expected %0h (result %0d)",
                 what, got, exp, results_seen);
        errors++;
    endtask

    // Sticky fault: OR in the flag, drop the count and go to fault mode.
    function automatic void latch_fault(input logic [3:0] b);
        flt = flt | b;
        cnt = '0;
        md = MODE_FAULT;
    endfunction

    function automatic t_out predict_mode(input t_in s);
        t_out r;
        logic [30:0] mag;
        bit cfg_bad;
        mag = s.angle_bits[30:0];
        cfg_bad = (need == 0) || (need > MAX_CAPTURE_SAMPLES) ||
                  (tmo == 0) || (tmo > MAX_TIMEOUT_US);
        if (cfg_bad) begin
            latch_fault(FLT_CONFIG);
        end else if (md >= MODE_FAULT) begin
            if (!s.arm_cmd && s.fault_clr_cmd) begin
                md = MODE_DISABLED; flt = '0; cnt = '0;
            end
        end else if (!s.arm_cmd) begin
            md = MODE_DISABLED; flt = '0; cnt = '0;
        end else if (!s.sample_ok || s.angle_bits[30:23] == 8'hFF) begin
            latch_fault(FLT_INVALID);
        end else if (s.sample_age > tmo) begin
            latch_fault(FLT_TIMEOUT);
        end else begin
            case (md)
                MODE_DISABLED, MODE_READY: begin
                    if (mag <= cap_lim) begin
                        md = MODE_CAPTURE;
                        cnt = 17'd1;
                        if (cnt >= need) md = MODE_BALANCE;
                    end else begin
                        md = MODE_READY;
                        cnt = '0;
                    end
                end
                MODE_CAPTURE: begin
                    if (mag > cap_lim) begin
                        md = MODE_READY;
                        cnt = '0;
                    end else begin
                        if (cnt < need) cnt = cnt + 17'd1;
                        if (cnt >= need) md = MODE_BALANCE;
                    end
                end
                default: begin
                    if (mag > esc_lim) latch_fault(FLT_ESCAPE);
                end
            endcase
        end
        r.balance_enable = (md == MODE_BALANCE);
        r.mode_out = md;
        r.fault_bits = flt;
        return r;
    endfunction

    // Sends one request after a random gap; prediction happens on acceptance.
    // Valid drops only for a real gap, so back-to-back requests keep it high.
    task automatic send_sample(input t_in s);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data <= s;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(predict_mode(s));
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CAPTURE_LIMIT: cap_lim = val[30:0];
            REG_ESCAPE_LIMIT:  esc_lim = val[30:0];
            REG_SAMPLES:       need = val[16:0];
            default:           tmo = val[23:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in mk(input bit arm, input bit clr, input bit ok,
                               input logic [31:0] ang, input logic [23:0] age);
        t_in s;
        s.arm_cmd = arm; s.fault_clr_cmd = clr; s.sample_ok = ok;
        s.angle_bits = ang; s.sample_age = age;
        return s;
    endfunction

    // Receiver: randomly drawn stall, plus a long hold-off on request and a stall-free mode.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_stall <= 1'b1;
        end else if (stall_free) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 19) < $urandom_range(0, 19));
        end
    end

    // Result checker against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", 32'(o_data), 32'd0);
            end else begin
                t_out e;
                e = expected_results.pop_front();
                if (o_data.balance_enable !== e.balance_enable)
                    report("balance_enable", 32'(o_data.balance_enable),
                           32'(e.balance_enable));
                if (o_data.mode_out !== e.mode_out)
                    report("mode_out", 32'(o_data.mode_out), 32'(e.mode_out));
                if (o_data.fault_bits !== e.fault_bits)
                    report("fault_bits", 32'(o_data.fault_bits), 32'(e.fault_bits));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Directed: reset config, extremes, every fault path, clear and disarm.
    task automatic test_directed;
        send_sample(mk(1, 0, 1, 32'h0000_0000, 24'd0));     // capture to balance
        send_sample(mk(1, 0, 1, 32'h8000_0000, 24'd10000)); // -0 in balance
        send_sample(mk(1, 0, 1, 32'h0000_0001, 24'd0));     // escape fault
        send_sample(mk(1, 1, 1, 32'h0, 24'd0));             // stays in fault
        send_sample(mk(0, 0, 1, 32'h0, 24'd0));             // no clear
        send_sample(mk(0, 1, 0, 32'hFFFF_FFFF, 24'hFFFFFF));// clear
        send_sample(mk(1, 0, 0, 32'h0, 24'd0));             // invalid sample
        send_sample(mk(0, 1, 1, 32'h0, 24'd0));
        send_sample(mk(1, 0, 1, 32'h7F80_0000, 24'd0));     // infinity
        send_sample(mk(0, 1, 1, 32'h0, 24'd0));
        send_sample(mk(1, 0, 1, 32'hFFC0_0001, 24'd0));     // NaN
        send_sample(mk(0, 1, 1, 32'h0, 24'd0));
        send_sample(mk(1, 0, 1, 32'h0, 24'd10001));         // timeout
        send_sample(mk(0, 1, 1, 32'h0, 24'd0));
        send_sample(mk(1, 1, 1, 32'h3F80_0000, 24'd5));     // ready
        send_sample(mk(0, 0, 1, 32'h0, 24'd0));             // disarm
        write_reg(REG_SAMPLES, 32'd0);                       // config fault
        send_sample(mk(0, 1, 1, 32'h0, 24'd0));
        write_reg(REG_SAMPLES, 32'd100001);
        send_sample(mk(1, 0, 1, 32'h0, 24'd0));
        write_reg(REG_SAMPLES, 32'd100000);
        write_reg(REG_TIMEOUT, 32'd0);
        send_sample(mk(0, 1, 1, 32'h0, 24'd0));
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        send_sample(mk(0, 1, 1, 32'h0, 24'd0));
        write_reg(REG_TIMEOUT, 32'd10000000);
        send_sample(mk(0, 1, 1, 32'h0, 24'd0));
        send_sample(mk(0, 1, 1, 32'h0, 24'd0));
    endtask

    // Mostly well-formed arm/capture/balance runs with random content.
    task automatic test_random(input int n, input logic [30:0] clim,
                               input logic [30:0] elim, input logic [16:0] nd,
                               input logic [23:0] to);
        t_in s;
        int k;
        write_reg(REG_CAPTURE_LIMIT, {1'($urandom_range(0, 1)), clim});
        write_reg(REG_ESCAPE_LIMIT, {1'($urandom_range(0, 1)), elim});
        write_reg(REG_SAMPLES, {15'($urandom()), nd});
        write_reg(REG_TIMEOUT, {8'($urandom_range(0, 255)), to});
        for (int i = 0; i < n; i++) begin
            s.arm_cmd = 1'($urandom());
            s.fault_clr_cmd = 1'($urandom());
            s.sample_ok = 1'($urandom());
            s.angle_bits = $urandom();
            s.sample_age = 24'($urandom());
            k = $urandom_range(0, 99);
            if (k < 80) begin
                s.arm_cmd = (md >= MODE_FAULT) ? ($urandom_range(0, 3) == 0) : 1'b1;
                s.fault_clr_cmd = (md >= MODE_FAULT) ? 1'b1 : 1'($urandom_range(0, 1));
                s.sample_ok = ($urandom_range(0, 30) != 0);
                if ($urandom_range(0, 3) != 0) begin
                    s.angle_bits[30:0] = (k < 60) ? 31'($urandom_range(0, clim)) :
                                          31'($urandom_range(0, elim));
                end
                if ($urandom_range(0, 20) != 0) s.sample_age = 24'($urandom_range(0, to));
            end
            send_sample(s);
        end
    endtask

    // Receiver holds off while the sender keeps offering, so input stalls.
    task automatic test_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            test_random(30, 31'h3F80_0000, 31'h4000_0000, 17'd2, 24'd500);
        join
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_random(200, 31'h3E00_0000, 31'h3F00_0000, 17'd3, 24'd1000);
        test_random(200, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 17'd1, 24'd10000000);
        test_random(150, 31'h0000_0000, 31'h0000_0000, 17'd1, 24'd1);
        stall_free = 1'b1;
        test_random(120, 31'h7F80_0000, 31'h3C00_0000, 17'd8, 24'hFFFFFF);
        stall_free = 1'b0;
        test_random(150, 31'h4000_0000, 31'h4100_0000, 17'd5, 24'd200);
        drain();
        $display("sent %0d samples across directed fault paths and six register sets,",
                 requests_sent);
        $display("checked %0d results including a long receiver hold-off", results_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
